// ===== rtl/urad_pkg.sv =====
// Shared types and constants for the ultrasonic ranging block.
package urad_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ECHO_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_COOLDOWN     = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD    = 2'd2;

  localparam logic [15:0] ECHO_TIMEOUT_RST = 16'd600;
  localparam logic [15:0] COOLDOWN_RST     = 16'd1200;
  localparam logic [9:0]  THRESHOLD_RST    = 10'd5;

  // distance = floor(ticks*25/29) = (ticks * 25 * ceil(2^26/29)) >> 26, exact below 2^17 ticks.
  // Ticks at or above TICK_CLAMP all saturate to DIST_MAX, so the count is clamped first.
  localparam int unsigned     DIST_SHIFT = 26;
  localparam logic [25:0]     DIST_MULT  = 26'd57852475;
  localparam logic [31:0]     TICK_CLAMP = 32'd76022;
  localparam logic [15:0]     DIST_MAX   = 16'hFFFF;

  // timing limits used by the sequencer
  typedef struct packed {
    logic [15:0] echo_timeout;
    logic [15:0] cooldown;
  } limits_t;

endpackage

// ===== rtl/urad_front.sv =====
// Front end: five-phase trigger/echo sequencer that classifies each tick.
module urad_front import urad_pkg::*; #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic                    echo_level,
  input  limits_t                 limits,
  output logic                    trig,
  output logic                    meas,
  output logic [COUNTER_BITS-1:0] tick
);

  localparam int CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
  localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_TRIG = 3'd0,
    PH_RISE = 3'd1,
    PH_WAIT = 3'd2,
    PH_MEAS = 3'd3,
    PH_COOL = 3'd4
  } phase_t;

  phase_t                  phase, phase_next;
  logic [COUNTER_BITS-1:0] tick_count, tick_count_next;
  logic [COUNTER_BITS-1:0] cnt_up;

  assign cnt_up = (tick_count == CNT_MAX) ? tick_count : tick_count + 1'b1;

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    case (phase)
      PH_TRIG: phase_next = PH_RISE;
      PH_RISE: begin
        tick_count_next = '0;
        phase_next      = PH_WAIT;
      end
      PH_WAIT: begin
        if (echo_level) begin
          tick_count_next = '0;
          phase_next      = PH_MEAS;
        end else begin
          tick_count_next = cnt_up;
          if (CMP_W'(cnt_up) > CMP_W'(limits.echo_timeout)) phase_next = PH_COOL;
        end
      end
      PH_MEAS: begin
        if (echo_level) begin
          tick_count_next = cnt_up;
        end else begin
          tick_count_next = '0;
          phase_next      = PH_COOL;
        end
      end
      PH_COOL: begin
        tick_count_next = cnt_up;
        if (CMP_W'(cnt_up) > CMP_W'(limits.cooldown)) phase_next = PH_TRIG;
      end
      default: phase_next = PH_RISE;
    endcase
  end

  // word handed to the back end
  assign trig = (phase_next == PH_RISE);
  assign meas = (phase == PH_MEAS) && !echo_level;
  assign tick = tick_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TRIG;
      tick_count <= '0;
    end else if (take) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

// ===== rtl/urad_fifo.sv =====
// Short word queue between the sequencer and the distance back end.
module urad_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CFULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign full    = (count == CFULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/urad_back.sv =====
// Back end: distance scaling, approach check, LED state and result register.
module urad_back import urad_pkg::*; #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  logic                    head_trig,
  input  logic                    head_meas,
  input  logic [COUNTER_BITS-1:0] head_tick,
  input  logic [9:0]              threshold,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    trigger_level,
  output logic                    led_lit,
  output logic                    distance_valid,
  output logic [15:0]             distance_cm,
  output logic [15:0]             approach_cm
);

  localparam int QW = 17;
  localparam int PW = QW + 26;

  logic          advance;
  logic [QW-1:0] tick_c;
  logic [PW-1:0] prod;

  // stage 1: scaled count
  logic          s1_valid;
  logic          s1_trig;
  logic          s1_meas;
  logic [QW-1:0] s1_quo;

  // measurement history
  logic          first_meas;
  logic          led_reg;
  logic [15:0]   prev_dist;

  logic [15:0]   cur_dist;
  logic [15:0]   approach;
  logic          led_new;

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && head_valid;

  assign tick_c = (32'(head_tick) >= TICK_CLAMP) ? QW'(TICK_CLAMP) : QW'(head_tick);
  assign prod   = PW'(tick_c) * PW'(DIST_MULT);

  always_comb begin
    cur_dist = '0;
    approach = '0;
    led_new  = led_reg;
    if (s1_meas) begin
      cur_dist = s1_quo[QW-1] ? DIST_MAX : s1_quo[15:0];
      if (!first_meas) begin
        approach = (prev_dist > cur_dist) ? prev_dist - cur_dist : '0;
        led_new  = approach >= 16'(threshold);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_trig <= head_trig;
      s1_meas <= head_meas;
      s1_quo  <= prod[PW-1:DIST_SHIFT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      first_meas <= 1'b1;
      led_reg    <= 1'b0;
      prev_dist  <= '0;
    end else if (advance) begin
      s1_valid  <= head_valid;
      out_valid <= s1_valid;
      if (s1_valid && s1_meas) begin
        first_meas <= 1'b0;
        led_reg    <= led_new;
        prev_dist  <= cur_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      trigger_level  <= s1_trig;
      led_lit        <= led_new;
      distance_valid <= s1_meas;
      distance_cm    <= cur_dist;
      approach_cm    <= approach;
    end
  end

endmodule

// ===== rtl/ultrasonic_ranging_approach_detect.sv =====
// Top level: ultrasonic echo-ranging sequencer with approach detection.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-------------------------------------------
//  in      | input     | in_valid / in_stall   | echo_level
//  out     | output    | out_valid / out_stall | trigger_level, led_lit, distance_valid,
//          |           |                       | distance_cm, approach_cm
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One tick word is taken per cycle while in_stall is low; its result word goes through
//  the queue write at the accepting edge, the multiply stage and the result register.
//  The sequencer works at acceptance; a four-word queue lets it run ahead of the back end.
//  in_stall rises only on a full queue; with out_valid set, out_stall freezes the back end.
//  rst is synchronous: sequencer in trigger phase, queue empty, registers at defaults.
module ultrasonic_ranging_approach_detect import urad_pkg::*; #(
  parameter int COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        echo_level,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        trigger_level,
  output logic        led_lit,
  output logic        distance_valid,
  output logic [15:0] distance_cm,
  output logic [15:0] approach_cm,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int WW = COUNTER_BITS + 2;

  limits_t                 limits;
  logic [9:0]              threshold;
  logic                    take;
  logic                    f_trig, f_meas;
  logic [COUNTER_BITS-1:0] f_tick;
  logic [WW-1:0]           head;
  logic                    q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.echo_timeout <= ECHO_TIMEOUT_RST;
      limits.cooldown     <= COOLDOWN_RST;
      threshold           <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ECHO_TIMEOUT: limits.echo_timeout <= cfg_data;
        CFG_COOLDOWN:     limits.cooldown     <= cfg_data;
        CFG_THRESHOLD:    threshold           <= cfg_data[9:0];
        default:          ;
      endcase
    end
  end

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;

  urad_front #(.COUNTER_BITS(COUNTER_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .echo_level (echo_level),
    .limits     (limits),
    .trig       (f_trig),
    .meas       (f_meas),
    .tick       (f_tick)
  );

  urad_fifo #(.WIDTH(WW), .DEPTH(4)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .push_data ({f_trig, f_meas, f_tick}),
    .pop       (q_pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  urad_back #(.COUNTER_BITS(COUNTER_BITS)) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (!q_empty),
    .head_trig      (head[WW-1]),
    .head_meas      (head[WW-2]),
    .head_tick      (head[COUNTER_BITS-1:0]),
    .threshold      (threshold),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trigger_level  (trigger_level),
    .led_lit        (led_lit),
    .distance_valid (distance_valid),
    .distance_cm    (distance_cm),
    .approach_cm    (approach_cm)
  );

  // trigger and measurement completion fall in different phases
  a_trig_meas_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(trigger_level && distance_valid))
    else $error("trigger and measurement in the same word");

  // approach only reported with a completed measurement
  a_approach_needs_meas: assert property (@(posedge clk) disable iff (rst)
    (out_valid && approach_cm != 16'd0) |-> distance_valid)
    else $error("approach without measurement");

  // no distance outside a measurement word
  a_dist_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !distance_valid) |-> (distance_cm == 16'd0))
    else $error("distance set without measurement");

  // a trigger word is followed by one without trigger
  a_trig_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && trigger_level) ##1 out_valid |-> !trigger_level)
    else $error("trigger held over two ticks");

endmodule

// ===== verif/ranging_tb_pkg.sv =====
// Word types and the tick-by-tick scoreboard for the ranging block bench.
package ranging_tb_pkg;
  import urad_pkg::*;

  typedef enum logic [2:0] {
    PH_TRIGGER  = 3'd0,
    PH_PULSE    = 3'd1,
    PH_WAIT     = 3'd2,
    PH_MEASURE  = 3'd3,
    PH_COOLDOWN = 3'd4
  } seq_phase_t;

  typedef struct packed {
    logic        trigger;
    logic        led;
    logic        dist_valid;
    logic [15:0] dist_cm;
    logic [15:0] approach;
  } range_word_t;

  class ranging_scoreboard;
    logic [15:0] timeout_lim;
    logic [15:0] cooldown_lim;
    logic [9:0]  threshold;
    seq_phase_t  phase;
    logic [15:0] count;
    logic [15:0] last_dist;
    bit          first;
    bit          led;
    range_word_t due[$];
    int          errors;

    function new();
      timeout_lim  = ECHO_TIMEOUT_RST;
      cooldown_lim = COOLDOWN_RST;
      threshold    = THRESHOLD_RST;
      phase        = PH_TRIGGER;
      count        = '0;
      last_dist    = '0;
      first        = 1'b1;
      led          = 1'b0;
      errors       = 0;
    endfunction

    function void note_config(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_ECHO_TIMEOUT: timeout_lim = data;
        CFG_COOLDOWN:     cooldown_lim = data;
        CFG_THRESHOLD:    threshold = data[9:0];
        default: ;  // spare index, no register behind it
      endcase
    endfunction

    // saturating tick counter
    function logic [15:0] bump(logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    function void note_tick(logic echo);
      range_word_t w;
      logic [31:0] scaled;
      w = '0;
      case (phase)
        PH_PULSE: begin
          count = '0;
          phase = PH_WAIT;
        end
        PH_WAIT: begin
          if (echo) begin
            count = '0;
            phase = PH_MEASURE;
          end else begin
            // timeout leaves the count as it is; cooldown carries on from it
            count = bump(count);
            if (count > timeout_lim) phase = PH_COOLDOWN;
          end
        end
        PH_MEASURE: begin
          if (echo) begin
            count = bump(count);
          end else begin
            scaled       = {16'd0, count} * 32'd50 / 32'd58;
            w.dist_valid = 1'b1;
            w.dist_cm    = scaled[15:0];
            count        = '0;
            phase        = PH_COOLDOWN;
          end
        end
        PH_COOLDOWN: begin
          count = bump(count);
          if (count > cooldown_lim) phase = PH_TRIGGER;
        end
        default: phase = PH_PULSE;
      endcase
      if (w.dist_valid) begin
        if (first) begin
          first = 1'b0;
        end else begin
          w.approach = (last_dist > w.dist_cm) ? last_dist - w.dist_cm : 16'd0;
          led        = (w.approach >= {6'd0, threshold});
        end
        last_dist = w.dist_cm;
      end
      w.trigger = (phase == PH_PULSE);
      w.led     = led;
      due.push_back(w);
    endfunction

    function void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(range_word_t got);
      range_word_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected word, expected none got %h", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      check_field("trigger_level", want.trigger, got.trigger);
      check_field("led_lit", want.led, got.led);
      check_field("distance_valid", want.dist_valid, got.dist_valid);
      check_field("distance_cm", want.dist_cm, got.dist_cm);
      check_field("approach_cm", want.approach, got.approach);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

endpackage

// ===== verif/tb.sv =====
// Bench top: drives echo ticks and register writes, checks every result word.
module tb;
  import urad_pkg::*;
  import ranging_tb_pkg::*;

  localparam logic [1:0]  CFG_UNUSED      = 2'd3;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          PRESSURE_CYCLES = 64;
  // ~1300 ticks, each at worst a long gap plus a long stall, with wide margin
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        echo_level = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        trigger_level;
  logic        led_lit;
  logic        distance_valid;
  logic [15:0] distance_cm;
  logic [15:0] approach_cm;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_ECHO_TIMEOUT;
  logic [15:0] cfg_data = '0;

  ranging_scoreboard sb = new();

  int          idle_pct = 40;
  int          noise_pct = 8;
  bit          pressure_req = 1'b0;
  seq_phase_t  last_phase = PH_TRIGGER;
  int          phase_ticks = 0;
  int          wait_plan = 0;
  int          echo_plan = 0;
  int          prev_echo_len = 30;
  bit          echo_script[$];
  int unsigned cycle_count = 0;

  ultrasonic_ranging_approach_detect dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .echo_level     (echo_level),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .trigger_level  (trigger_level),
    .led_lit        (led_lit),
    .distance_valid (distance_valid),
    .distance_cm    (distance_cm),
    .approach_cm    (approach_cm),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // mostly no gap, some short, a few long
  function automatic int pick_gap();
    int r;
    if ($urandom_range(99) >= idle_pct) return 0;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int plan_wait();
    int lim;
    lim = int'(sb.timeout_lim);
    // now and then let the wait run into the timeout
    if (lim < 100 && $urandom_range(99) < 15) return lim + 1 + $urandom_range(2);
    return $urandom_range(0, (lim < 12) ? lim : 12);
  endfunction

  function automatic int plan_echo();
    int len;
    int r;
    // drift up and down around the last echo so approaches and retreats both occur
    r = $urandom_range(99);
    if (prev_echo_len > 200 || r < 30) len = $urandom_range(0, 60);
    else if (r < 70) len = prev_echo_len - int'($urandom_range(0, 15));
    else len = prev_echo_len + int'($urandom_range(0, 15));
    if (len < 0) len = $urandom_range(20, 80);
    prev_echo_len = len;
    return len;
  endfunction

  // follows the predicted sequencer so that echoes land in the wait and measure phases
  function automatic logic next_echo();
    if (sb.phase != last_phase) begin
      last_phase  = sb.phase;
      phase_ticks = 0;
      if (sb.phase == PH_WAIT) wait_plan = plan_wait();
      if (sb.phase == PH_MEASURE) echo_plan = plan_echo();
    end else begin
      phase_ticks++;
    end
    if (echo_script.size() != 0) return echo_script.pop_front();
    if ($urandom_range(99) < noise_pct) return 1'($urandom_range(1));
    case (sb.phase)
      PH_WAIT:    return phase_ticks >= wait_plan;
      PH_MEASURE: return phase_ticks < echo_plan;
      default:    return 1'($urandom_range(3) == 0);
    endcase
  endfunction

  task automatic send_ticks(input int n);
    int sent;
    int gap;
    sent = 0;
    while (sent < n) begin
      gap = pick_gap();
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid   <= 1'b1;
      echo_level <= next_echo();
      @(posedge clk);
      while (in_stall) @(posedge clk);
      sb.note_tick(echo_level);
      sent++;
    end
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, data);
  endtask

  task automatic configure(input logic [15:0] tmo, input logic [15:0] cool,
                           input logic [15:0] thr, input bit stray);
    if (stray) write_reg(CFG_UNUSED, 16'($urandom));
    write_reg(CFG_ECHO_TIMEOUT, tmo);
    write_reg(CFG_COOLDOWN, cool);
    write_reg(CFG_THRESHOLD, thr);
    cfg_valid <= 1'b0;
  endtask

  // drain, then allow the pipe to go quiet
  task automatic settle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int          stall_left;
    int          g;
    range_word_t seen;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        seen = {trigger_level, led_lit, distance_valid, distance_cm, approach_cm};
        sb.check_result(seen);
      end
      if (pressure_req) begin
        pressure_req = 1'b0;
        stall_left   = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        g = pick_gap();
        out_stall <= (g > 0);
        stall_left = (g > 0) ? g - 1 : 0;
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults: first measurement only stores the distance
    echo_script = '{1, 0, 0, 0, 1, 1, 1, 1, 1, 1, 1, 0};
    send_ticks(12);
    settle();

    // zero timeout, zero cooldown, zero threshold: timeout then a zero-length echo
    configure(16'd0, 16'd0, 16'd0, 1'b0);
    echo_script = '{0, 1, 0, 0, 0, 0, 0, 1, 0};
    send_ticks(9);
    settle();

    configure(16'd20, 16'd10, 16'd5, 1'b1);
    idle_pct     = 0;
    pressure_req = 1'b1;
    send_ticks(80);
    settle();
    idle_pct = 40;
    send_ticks(200);
    settle();

    configure(16'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
              16'($urandom_range(0, 30)), 1'b0);
    send_ticks(200);
    settle();

    // top threshold; upper data bits are dropped by the register
    configure(16'd8, 16'd5, 16'hFFFF, 1'b1);
    send_ticks(200);
    settle();

    // wait limit at the counter ceiling: the wait only ends on an echo
    configure(16'hFFFF, 16'd3, 16'd7, 1'b0);
    send_ticks(200);
    settle();

    repeat (4) begin
      configure($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 20)),
                16'($urandom_range(0, 40)),
                $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(0, 12)),
                1'($urandom_range(1)));
      send_ticks(80);
      settle();
    end

    // cooldown at the counter ceiling never ends
    configure(16'd10, 16'hFFFF, 16'd0, 1'b0);
    send_ticks(100);
    settle();

    if (sb.errors == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

// ===== ultrasonic_ranging_approach_detect.f =====
rtl/urad_pkg.sv
rtl/urad_front.sv
rtl/urad_fifo.sv
rtl/urad_back.sv
rtl/ultrasonic_ranging_approach_detect.sv
verif/ranging_tb_pkg.sv
verif/tb.sv
